@@ design/fixed_block_free_list_allocator_assert.svh @@
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator_assert.svh
// Assertion macros shared by the free-list allocator
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH
`define FIXED_BLOCK_FREE_LIST_ALLOCATOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FBFLA_ASSERT_IMPL(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("fbfla same-cycle check failed");

// next-cycle implication, checked outside reset
`define FBFLA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("fbfla next-cycle check failed");

`endif

@@ design/fbfla_pkg.sv @@
// ----------------------------------------------------------------------------
// fbfla_pkg
// Types and constants of the fixed-block free-list allocator
// ----------------------------------------------------------------------------
package fbfla_pkg;

  // field widths
  localparam int KIND_W     = 2;
  localparam int REL_W      = 4;
  localparam int STATUS_W   = 2;
  localparam int GIDX_W     = 4;
  localparam int ADDR_W     = 32;
  localparam int FREE_W     = 5;
  localparam int COUNT_W    = 5;
  localparam int BYTES_W    = 9;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  // register reset values
  localparam logic [COUNT_W-1:0] COUNT_RST = 5'd10;
  localparam logic [BYTES_W-1:0] BYTES_RST = 9'd12;
  localparam logic [ADDR_W-1:0]  BASE_RST  = 32'd0;

  // operation codes
  typedef enum logic [KIND_W-1:0] {
    KIND_ALLOC = 2'd0,
    KIND_FREE  = 2'd1,
    KIND_INIT  = 2'd2
  } kind_t;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_NULL    = 2'd2,
    ST_INVALID = 2'd3
  } status_t;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POOL_SIZE    = 2'd0,
    CFG_BLOCK_BYTES  = 2'd1,
    CFG_BASE_ADDRESS = 2'd2
  } cfg_idx_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic init_step;
    logic alloc_pop;
    logic hold_load;
    logic out_load;
    logic out_sel_hold;
  } ctrl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic alloc_go;
    logic init_go;
    logic init_last;
  } dp_sts_t;

endpackage

@@ design/fbfla_ram.sv @@
// ----------------------------------------------------------------------------
// fbfla_ram
// Generic single-write, single-read RAM with registered read data
// ----------------------------------------------------------------------------
module fbfla_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

@@ design/fbfla_ctrl.sv @@
// ----------------------------------------------------------------------------
// fbfla_ctrl
// Controller state machine of the free-list allocator
// ----------------------------------------------------------------------------
module fbfla_ctrl
  import fbfla_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  dp_sts_t    sts,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_INIT  = 4'b0010,
    S_ALLOC = 4'b0100,
    S_HOLD  = 4'b1000
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   done;

  // output register can take a result this cycle
  assign out_free = !out_valid_r || !out_stall;

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    done      = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (sts.alloc_go) begin
            state_nxt = S_ALLOC;
          end else if (sts.init_go) begin
            state_nxt = S_INIT;
          end else begin
            done = 1'b1;
          end
        end
      end
      S_INIT: begin
        cmd.init_step = 1'b1;
        if (sts.init_last) begin
          done = 1'b1;
        end
      end
      S_ALLOC: begin
        cmd.alloc_pop = 1'b1;
        done          = 1'b1;
      end
      S_HOLD: begin
        if (out_free) begin
          cmd.out_load     = 1'b1;
          cmd.out_sel_hold = 1'b1;
          state_nxt        = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
    // finished result goes to output or to the hold stage
    if (done) begin
      if (out_free) begin
        cmd.out_load = 1'b1;
        state_nxt    = S_IDLE;
      end else begin
        cmd.hold_load = 1'b1;
        state_nxt     = S_HOLD;
      end
    end
  end

  // output valid tracking
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

endmodule

@@ design/fbfla_dp.sv @@
// ----------------------------------------------------------------------------
// fbfla_dp
// Datapath of the free-list allocator: registers, link RAM, result stages
// ----------------------------------------------------------------------------
module fbfla_dp
  import fbfla_pkg::*;
#(
  parameter int POOL_BLOCKS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [REL_W-1:0]      in_release_index,
  input  logic                  in_release_null,
  input  ctrl_cmd_t             cmd,
  output dp_sts_t               sts,
  output logic [STATUS_W-1:0]   out_status,
  output logic [GIDX_W-1:0]     out_granted_index,
  output logic [ADDR_W-1:0]     out_granted_address,
  output logic [FREE_W-1:0]     out_blocks_free
);

  localparam int IDX_W = $clog2(POOL_BLOCKS);
  localparam int CW    = ((IDX_W > FREE_W) ? IDX_W : FREE_W) + 1;
  localparam int PW    = IDX_W + BYTES_W;

  // configuration registers
  logic [COUNT_W-1:0] pool_size_r;
  logic [BYTES_W-1:0] block_bytes_r;
  logic [ADDR_W-1:0]  base_address_r;

  // free list state
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [FREE_W-1:0] free_total_r, free_nxt;
  logic [IDX_W-1:0]  cnt_r, cnt_nxt;
  logic [FREE_W-1:0] ninit_r, ninit_nxt;

  // link RAM ports
  logic             wr_en, rd_en;
  logic [IDX_W-1:0] wr_addr, rd_addr;
  logic [IDX_W-1:0] wr_data, rd_data;

  // result of the current cycle and the hold stage
  status_t           res_status, hold_status_r;
  logic [GIDX_W-1:0] res_gidx, hold_gidx_r;
  logic [ADDR_W-1:0] res_addr, hold_addr_r;
  logic [FREE_W-1:0] hold_free_r;

  // output register
  logic [STATUS_W-1:0] out_status_r;
  logic [GIDX_W-1:0]   out_gidx_r;
  logic [ADDR_W-1:0]   out_addr_r;
  logic [FREE_W-1:0]   out_free_r;

  kind_t             kind;
  logic [FREE_W-1:0] n_now;
  logic [IDX_W-1:0]  rel_idx;
  logic              free_ok;
  logic              init_last;
  logic [PW-1:0]     prod;

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pool_size_r    <= COUNT_RST;
      block_bytes_r  <= BYTES_RST;
      base_address_r <= BASE_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_POOL_SIZE:    pool_size_r    <= cfg_wr_data[COUNT_W-1:0];
        CFG_BLOCK_BYTES:  block_bytes_r  <= cfg_wr_data[BYTES_W-1:0];
        CFG_BASE_ADDRESS: base_address_r <= cfg_wr_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // blocks in use: configured pool size clamped to POOL_BLOCKS
  always_comb begin
    if (CW'(pool_size_r) > CW'(POOL_BLOCKS)) begin
      n_now = FREE_W'(POOL_BLOCKS);
    end else begin
      n_now = pool_size_r;
    end
  end

  assign kind      = kind_t'(in_kind);
  assign rel_idx   = IDX_W'(CW'(in_release_index));
  assign free_ok   = (FREE_W'(in_release_index) < n_now) && (free_total_r < n_now);
  assign init_last = ((CW'(cnt_r) + CW'(1)) == CW'(ninit_r));
  assign prod      = PW'(head_r) * PW'(block_bytes_r);

  // status to the controller
  assign sts.alloc_go  = (kind == KIND_ALLOC) && (free_total_r != '0);
  assign sts.init_go   = (kind == KIND_INIT) && (n_now != '0);
  assign sts.init_last = init_last;

  // free list update, link RAM access and result
  always_comb begin
    head_nxt   = head_r;
    free_nxt   = free_total_r;
    cnt_nxt    = cnt_r;
    ninit_nxt  = ninit_r;
    wr_en      = 1'b0;
    wr_addr    = rel_idx;
    wr_data    = head_r;
    rd_en      = 1'b0;
    rd_addr    = head_r;
    res_status = ST_OK;
    res_gidx   = '0;
    res_addr   = '0;
    if (cmd.accept) begin
      case (kind)
        KIND_ALLOC: begin
          if (free_total_r == '0) begin
            res_status = ST_EMPTY;
          end else begin
            rd_en = 1'b1;
          end
        end
        KIND_FREE: begin
          if (in_release_null) begin
            res_status = ST_NULL;
          end else if (!free_ok) begin
            res_status = ST_INVALID;
          end else begin
            wr_en    = 1'b1;
            head_nxt = rel_idx;
            free_nxt = free_total_r + FREE_W'(1);
          end
        end
        KIND_INIT: begin
          head_nxt  = '0;
          free_nxt  = n_now;
          ninit_nxt = n_now;
          cnt_nxt   = '0;
        end
        default: ;
      endcase
    end
    // one link written per cycle during the init walk
    if (cmd.init_step) begin
      wr_en   = 1'b1;
      wr_addr = cnt_r;
      wr_data = init_last ? '0 : (cnt_r + IDX_W'(1));
      cnt_nxt = cnt_r + IDX_W'(1);
    end
    // pop the head once its link has been read
    if (cmd.alloc_pop) begin
      head_nxt = rd_data;
      free_nxt = free_total_r - FREE_W'(1);
      res_gidx = GIDX_W'(CW'(head_r));
      res_addr = base_address_r + ADDR_W'(prod);
    end
  end

  // free list registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      free_total_r <= '0;
    end else begin
      head_r       <= head_nxt;
      free_total_r <= free_nxt;
    end
  end

  // init walk counters
  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    ninit_r <= ninit_nxt;
  end

  // hold stage for a result that meets a stalled output
  always_ff @(posedge clk) begin
    if (cmd.hold_load) begin
      hold_status_r <= res_status;
      hold_gidx_r   <= res_gidx;
      hold_addr_r   <= res_addr;
      hold_free_r   <= free_nxt;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      if (cmd.out_sel_hold) begin
        out_status_r <= hold_status_r;
        out_gidx_r   <= hold_gidx_r;
        out_addr_r   <= hold_addr_r;
        out_free_r   <= hold_free_r;
      end else begin
        out_status_r <= res_status;
        out_gidx_r   <= res_gidx;
        out_addr_r   <= res_addr;
        out_free_r   <= free_nxt;
      end
    end
  end

  assign out_status          = out_status_r;
  assign out_granted_index   = out_gidx_r;
  assign out_granted_address = out_addr_r;
  assign out_blocks_free     = out_free_r;

  // link store
  fbfla_ram #(
    .WIDTH (IDX_W),
    .DEPTH (POOL_BLOCKS)
  ) u_link_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

endmodule

@@ design/fixed_block_free_list_allocator.sv @@
// ----------------------------------------------------------------------------
// fixed_block_free_list_allocator
// Fixed-size block pool allocator kept as a last-in first-out free list
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall) carries one operation per transfer:
// allocate, free or initialize. Every operation returns exactly one result
// on the output channel (out_valid / out_stall) with status, granted block
// index and byte address, and the free count after the operation.
// Free, rejected or null free, and allocate on an empty pool finish in
// the accepting cycle. An allocate with a free block reads the link RAM
// first, then pops the head. Initialize walks the blocks in use, one link
// written per cycle, and finishes in the accepting cycle when the clamped
// count in use is zero. Throughput is one free per cycle while the output
// is not stalled; an allocate with a free block holds off the next operation
// until its head pop, as the link RAM has one registered read port.
// A result that meets a stalled output waits in a one-entry hold stage, and
// in_stall stays high until it moves to the output register.
// Reset clears the free list to an empty pool (an initialize is needed
// first) and loads the configuration registers with their defaults. The
// link RAM is not cleared; only links written by initialize or free are read.
// Configuration writes are taken at any time but must only be issued idle.
// ----------------------------------------------------------------------------
`include "fixed_block_free_list_allocator_assert.svh"

module fixed_block_free_list_allocator
  import fbfla_pkg::*;
#(
  parameter int POOL_BLOCKS = 16
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [KIND_W-1:0]     in_kind,
  input  logic [REL_W-1:0]      in_release_index,
  input  logic                  in_release_null,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [STATUS_W-1:0]   out_status,
  output logic [GIDX_W-1:0]     out_granted_index,
  output logic [ADDR_W-1:0]     out_granted_address,
  output logic [FREE_W-1:0]     out_blocks_free
);

  ctrl_cmd_t cmd;
  dp_sts_t   dp_sts;

  // terms used by the checks below
  logic empty_result;
  logic error_result;
  logic no_grant;
  logic alloc_pop_xfer;

  // controller
  fbfla_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (dp_sts),
    .cmd       (cmd)
  );

  // datapath
  fbfla_dp #(
    .POOL_BLOCKS (POOL_BLOCKS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_wr_en           (cfg_wr_en),
    .cfg_index           (cfg_index),
    .cfg_wr_data         (cfg_wr_data),
    .in_kind             (in_kind),
    .in_release_index    (in_release_index),
    .in_release_null     (in_release_null),
    .cmd                 (cmd),
    .sts                 (dp_sts),
    .out_status          (out_status),
    .out_granted_index   (out_granted_index),
    .out_granted_address (out_granted_address),
    .out_blocks_free     (out_blocks_free)
  );

  assign empty_result   = out_valid && (out_status == ST_EMPTY);
  assign error_result   = out_valid && (out_status != ST_OK);
  assign no_grant       = (out_granted_index == '0) && (out_granted_address == '0);
  assign alloc_pop_xfer = in_valid && !in_stall && (in_kind == KIND_ALLOC) && dp_sts.alloc_go;

  // empty pool reports no free blocks
  `FBFLA_ASSERT_IMPL(a_empty_has_none, empty_result, out_blocks_free == '0)

  // only a successful allocate grants a block
  `FBFLA_ASSERT_IMPL(a_no_grant_on_error, error_result, no_grant)

  // an allocate that pops stalls the input while the link is read
  `FBFLA_ASSERT_NEXT(a_alloc_second_cycle, alloc_pop_xfer, in_stall)

endmodule
